// ===== hw/rtl/deq_pkg.sv =====
`timescale 1ns / 1ps

package deq_pkg;

	// Storage geometry. Indices run from 0 to DEPTH, so they need one more bit
	// than an address.
	localparam int DEPTH = 128;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int IDX_W = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;

	// Request commands.
	localparam logic [1:0] CMD_PUSH_BACK = 2'd0;
	localparam logic [1:0] CMD_PUSH_FRONT = 2'd1;
	localparam logic [1:0] CMD_POP_FRONT = 2'd2;
	localparam logic [1:0] CMD_POP_BACK = 2'd3;

	// Result status codes.
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_FRONT_BLOCKED = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic exec;
	} deq_cmd_t;

endpackage

// ===== hw/rtl/deq_ctrl.sv =====
`timescale 1ns / 1ps

module deq_ctrl import deq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	output logic     done,
	output deq_cmd_t dp_cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_RESP = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	// A new request may be taken while the previous result is shown.
	assign busy = (state_q == S_EXEC);
	assign accept = start && !busy;
	assign done = (state_q == S_RESP);

	assign dp_cmd.load = accept;
	assign dp_cmd.exec = (state_q == S_EXEC);

	// Next state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = S_RESP;
			end
			S_RESP: begin
				state_d = accept ? S_EXEC : S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

endmodule

// ===== hw/rtl/deq_dp.sv =====
`timescale 1ns / 1ps

module deq_dp import deq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  deq_cmd_t          dp_cmd,
	input  logic [1:0]        cmd,
	input  logic [DATA_W-1:0] push_value,
	output logic [DATA_W-1:0] pop_value,
	output logic [1:0]        status
);

	logic [DATA_W-1:0] mem [DEPTH];

	logic [1:0]        cmd_q;
	logic [DATA_W-1:0] val_q;
	logic [IDX_W-1:0]  first_q;
	logic [IDX_W-1:0]  end_q;
	logic [DATA_W-1:0] rd_q;
	logic [1:0]        status_q;
	logic              pop_ok_q;
	logic              empty_q;

	logic              is_push;
	logic              full;
	logic              empty;
	logic              front_dec;
	logic              end_dec;
	logic [1:0]        status_d;
	logic              wr_en;
	logic              rd_en;
	logic [IDX_W-1:0]  first_m1;
	logic [IDX_W-1:0]  end_m1;
	logic [ADDR_W-1:0] addr;

	// Capture the request.
	always_ff @(posedge clk) begin
		if (dp_cmd.load) begin
			cmd_q <= cmd;
			val_q <= push_value;
		end
	end

	// Decide the outcome from the current indices.
	always_comb begin
		is_push = (cmd_q == CMD_PUSH_BACK) || (cmd_q == CMD_PUSH_FRONT);
		full = (end_q == IDX_W'(DEPTH));
		empty = (first_q == end_q);
		first_m1 = first_q - IDX_W'(1);
		end_m1 = end_q - IDX_W'(1);
		wr_en = 1'b0;
		rd_en = 1'b0;
		front_dec = 1'b0;
		end_dec = 1'b0;
		status_d = ST_OK;
		addr = first_q[ADDR_W-1:0];
		case (cmd_q)
			CMD_PUSH_BACK: begin
				addr = end_q[ADDR_W-1:0];
				if (full) status_d = ST_FULL;
				else wr_en = 1'b1;
			end
			CMD_PUSH_FRONT: begin
				addr = first_m1[ADDR_W-1:0];
				if (full) status_d = ST_FULL;
				else if (first_q == '0) status_d = ST_FRONT_BLOCKED;
				else begin
					wr_en = 1'b1;
					front_dec = 1'b1;
				end
			end
			CMD_POP_FRONT: begin
				addr = first_q[ADDR_W-1:0];
				if (empty) status_d = ST_EMPTY;
				else rd_en = 1'b1;
			end
			CMD_POP_BACK: begin
				addr = end_m1[ADDR_W-1:0];
				if (empty) status_d = ST_EMPTY;
				else begin
					rd_en = 1'b1;
					end_dec = 1'b1;
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	// Index registers move only when a request succeeds.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= '0;
			end_q <= '0;
		end else if (dp_cmd.exec) begin
			if (front_dec) first_q <= first_m1;
			else if (rd_en && !end_dec) first_q <= first_q + IDX_W'(1);
			if (end_dec) end_q <= end_m1;
			else if (wr_en && !front_dec) end_q <= end_q + IDX_W'(1);
		end
	end

	// Storage with a registered read port.
	always_ff @(posedge clk) begin
		if (dp_cmd.exec && wr_en) mem[addr] <= val_q;
		if (dp_cmd.exec && rd_en) rd_q <= mem[addr];
	end

	// Result registers.
	always_ff @(posedge clk) begin
		if (dp_cmd.exec) begin
			status_q <= status_d;
			pop_ok_q <= rd_en;
			empty_q <= !is_push && empty;
		end
	end

	// A failed pop answers all ones; pushes answer zero.
	assign pop_value = pop_ok_q ? rd_q : (empty_q ? '1 : '0);
	assign status = status_q;

endmodule

// ===== hw/rtl/double_ended_queue_top.sv =====
// A request that is taken moves the controller to S_EXEC, and its result strobe,
// done, follows in S_RESP. A new request may be taken in S_RESP, not in S_EXEC:
// busy is high only in the state that updates indices and reads or writes storage.
// Reset: arst_n clears both indices and the controller; storage is not cleared.
// The receiver cannot stall: done marks each result for one cycle.
`timescale 1ns / 1ps

module double_ended_queue_top import deq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        cmd,
	input  logic [DATA_W-1:0] push_value,
	output logic              done,
	output logic [DATA_W-1:0] pop_value,
	output logic [1:0]        status
);

	deq_cmd_t dp_cmd;

	// Sequencing of each request.
	deq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.dp_cmd (dp_cmd)
	);

	// Indices, storage and result registers.
	deq_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.dp_cmd     (dp_cmd),
		.cmd        (cmd),
		.push_value (push_value),
		.pop_value  (pop_value),
		.status     (status)
	);

endmodule

// ===== test/tb_double_ended_queue_top.sv =====
`timescale 1ns / 1ps

module tb_double_ended_queue_top;
	import deq_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 100000;
	localparam int RANDOM_REQUESTS = 1200;
	localparam int SETTLE_CYCLES = 10;

	// Request mixes; each but CHURN leans on a single command to push the indices
	// toward one of the corner states.
	typedef enum {FILL_BACK, DRAIN_FRONT, FILL_FRONT, DRAIN_BACK, CHURN} traffic_t;

	// Mirror of the deque: it tracks both indices and the storage and holds the
	// results still owed by the block, oldest first.
	class deque_mirror;
		typedef struct {
			logic [DATA_W-1:0] word;
			logic [1:0]        code;
		} outcome_t;

		logic [DATA_W-1:0] words [DEPTH];
		logic [IDX_W-1:0]  head;
		logic [IDX_W-1:0]  tail;
		outcome_t          owed [$];
		int unsigned       errors;

		function new();
			head = '0;
			tail = '0;
			errors = 0;
		endfunction

		function int pending();
			return owed.size();
		endfunction

		// Apply one accepted request and queue the result it must produce.
		function void note_request(logic [1:0] op, logic [DATA_W-1:0] value);
			outcome_t res;
			res.word = '0;
			res.code = ST_OK;
			if (op == CMD_PUSH_BACK || op == CMD_PUSH_FRONT) begin
				// The full check comes first, for front pushes as well.
				if (tail == DEPTH) begin
					res.code = ST_FULL;
				end else if (op == CMD_PUSH_BACK) begin
					words[tail[ADDR_W-1:0]] = value;
					tail = tail + 1'b1;
				end else if (head == '0) begin
					res.code = ST_FRONT_BLOCKED;
				end else begin
					head = head - 1'b1;
					words[head[ADDR_W-1:0]] = value;
				end
			end else if (head == tail) begin
				res.word = '1;
				res.code = ST_EMPTY;
			end else if (op == CMD_POP_FRONT) begin
				res.word = words[head[ADDR_W-1:0]];
				head = head + 1'b1;
			end else begin
				tail = tail - 1'b1;
				res.word = words[tail[ADDR_W-1:0]];
			end
			owed.push_back(res);
		endfunction

		// Compare one result strobe with the oldest owed result.
		function void check_result(logic [DATA_W-1:0] word, logic [1:0] code);
			outcome_t exp;
			if (owed.size() == 0) begin
				$error("unexpected result: pop_value %h, status %0d", word, code);
				errors++;
				return;
			end
			exp = owed.pop_front();
			if (word !== exp.word) begin
				$error("pop_value mismatch: expected %h, actual %h", exp.word, word);
				errors++;
			end
			if (code !== exp.code) begin
				$error("status mismatch: expected %0d, actual %0d", exp.code, code);
				errors++;
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic [1:0]        cmd = CMD_PUSH_BACK;
	logic [DATA_W-1:0] push_value = '0;
	logic              busy;
	logic              done;
	logic [DATA_W-1:0] pop_value;
	logic [1:0]        status;

	deque_mirror mirror;
	int unsigned idle_pct = 0;
	int unsigned cycle_count = 0;

	double_ended_queue_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.push_value (push_value),
		.done       (done),
		.pop_value  (pop_value),
		.status     (status)
	);

	// 100 MHz clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Every result strobe is checked at the edge that ends its cycle.
	always @(posedge clk) begin
		if (arst_n && done) begin
			mirror.check_result(pop_value, status);
		end
	end

	// Watchdog for a hung handshake or a missing result.
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Test completed with failures");
		$finish;
	end

	// Issue one request, after a random number of idle cycles, and hold it until
	// the block takes it.
	task automatic send_request(input logic [1:0] op, input logic [DATA_W-1:0] value);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		cmd <= op;
		push_value <= value;
		do begin
			@(posedge clk);
		end while (busy);
		mirror.note_request(op, value);
	endtask

	// Draw a command: the favored one most of the time, any command otherwise.
	function automatic logic [1:0] pick_op(traffic_t mix);
		logic [1:0] favored;
		case (mix)
			FILL_BACK: begin
				favored = CMD_PUSH_BACK;
			end
			DRAIN_FRONT: begin
				favored = CMD_POP_FRONT;
			end
			FILL_FRONT: begin
				favored = CMD_PUSH_FRONT;
			end
			DRAIN_BACK: begin
				favored = CMD_POP_BACK;
			end
			default: begin
				return 2'($urandom_range(3));
			end
		endcase
		if ($urandom_range(99) < 80) begin
			return favored;
		end
		return 2'($urandom_range(3));
	endfunction

	initial begin
		traffic_t mix;
		int       seg_left;

		mirror = new();
		mix = CHURN;
		seg_left = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: blocked and empty cases at reset, extreme words, every
		// command, and the deque run back down to empty away from index zero.
		idle_pct = 37;
		send_request(CMD_PUSH_FRONT, 32'h1234_5678);
		send_request(CMD_POP_FRONT, 32'hFFFF_FFFF);
		send_request(CMD_POP_BACK, 32'h8000_0000);
		send_request(CMD_PUSH_BACK, 32'h7FFF_FFFF);
		send_request(CMD_PUSH_BACK, 32'h8000_0000);
		send_request(CMD_PUSH_BACK, 32'h0000_0000);
		send_request(CMD_PUSH_BACK, 32'hFFFF_FFFF);
		send_request(CMD_PUSH_BACK, 32'hAAAA_AAAA);
		send_request(CMD_PUSH_BACK, 32'h5555_5555);
		send_request(CMD_PUSH_FRONT, 32'h0BAD_0BAD);
		send_request(CMD_POP_FRONT, 32'h0000_0000);
		send_request(CMD_POP_FRONT, 32'h0000_0000);
		send_request(CMD_PUSH_FRONT, 32'hFFFF_FFFF);
		send_request(CMD_PUSH_FRONT, 32'h0000_0001);
		send_request(CMD_PUSH_FRONT, 32'h0000_0002);
		send_request(CMD_POP_BACK, 32'h0000_0000);
		send_request(CMD_POP_BACK, 32'h0000_0000);
		send_request(CMD_POP_FRONT, 32'h0000_0000);
		send_request(CMD_POP_FRONT, 32'h0000_0000);
		send_request(CMD_POP_FRONT, 32'h0000_0000);
		send_request(CMD_POP_FRONT, 32'h0000_0000);
		send_request(CMD_POP_BACK, 32'h7FFF_FFFF);
		send_request(CMD_POP_FRONT, 32'h8000_0000);

		// Random part in segments, each but CHURN leaning on one command so that the
		// indices reach full, blocked and empty over and over.
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n < RANDOM_REQUESTS / 3) begin
				idle_pct = 37;
			end else if (n < 2 * RANDOM_REQUESTS / 3) begin
				idle_pct = 58;
			end else begin
				idle_pct = 0;
			end
			if (seg_left == 0) begin
				mix = mix.next();
				seg_left = $urandom_range(100, 200);
			end
			seg_left--;
			send_request(pick_op(mix), $urandom);
		end
		start <= 1'b0;

		// Drain the owed results, then watch a little longer for strays.
		while (mirror.pending() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mirror.errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ===== double_ended_queue_top.f =====
hw/rtl/deq_pkg.sv
hw/rtl/deq_ctrl.sv
hw/rtl/deq_dp.sv
hw/rtl/double_ended_queue_top.sv
test/tb_double_ended_queue_top.sv
